/* rtl/core/vdpd_pkg.sv */
// Shared types, codes and defaults for the varint delta postings decoder.
`default_nettype none

package vdpd_pkg;

    // Field widths
    localparam int CMD_W    = 2;
    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 16;
    localparam int VERSE_W  = 16;
    localparam int STATUS_W = 3;
    localparam int GAP_W    = 32;
    localparam int STEP_W   = 3;
    localparam int GROUP_W  = 7;

    // Defaults for top-level parameters
    localparam int DEFAULT_MAX_GROUP_BYTES = 5;
    localparam int DEFAULT_QUEUE_DEPTH     = 2;

    // Input command codes
    localparam logic [CMD_W-1:0] CMD_START = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DATA  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_END   = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_POSTING  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_ASC  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_ENDED    = 3'd5;

    // Operation class decided by the front end
    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_DATA  = 2'd1,
        OP_END   = 2'd2
    } op_t;

    // One queued operation
    typedef struct packed {
        op_t               op;
        logic [BYTE_W-1:0] data_byte;
        logic [LEN_W-1:0]  list_length;
    } q_entry_t;

endpackage

`default_nettype wire

/* rtl/core/vdpd_front.sv */
// Front end: accepts input transfers, classifies commands, drops unused codes.
`default_nettype none

module vdpd_front
    import vdpd_pkg::*;
(
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [CMD_W-1:0]  cmd,
    input  wire logic [BYTE_W-1:0] data_byte,
    input  wire logic [LEN_W-1:0]  list_length,
    output logic                   push_valid,
    output q_entry_t               push_entry,
    input  wire logic              q_full
);

    logic is_known;

    // Stall only when the queue has no room
    assign in_stall = q_full;

    // Classify the command
    always_comb
    begin
        is_known = 1'b1;
        push_entry.op = OP_DATA;
        case (cmd)
            CMD_START: push_entry.op = OP_START;
            CMD_DATA:  push_entry.op = OP_DATA;
            CMD_END:   push_entry.op = OP_END;
            default:   is_known = 1'b0;
        endcase
        push_entry.data_byte   = data_byte;
        push_entry.list_length = list_length;
    end

    // Unused command is consumed here and never queued
    assign push_valid = in_valid && !q_full && is_known;

endmodule

`default_nettype wire

/* rtl/core/vdpd_queue.sv */
// Small FIFO between front end and decode back end.
`default_nettype none

module vdpd_queue
    import vdpd_pkg::*;
#(
    parameter int DEPTH = DEFAULT_QUEUE_DEPTH
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push_valid,
    input  wire q_entry_t push_entry,
    output logic          q_full,
    output logic          pop_valid,
    output q_entry_t      pop_entry,
    input  wire logic     pop_ready
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    q_entry_t             mem [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     count_reg,  count_next;
    logic                 do_push, do_pop;

    assign q_full    = (count_reg == CNT_W'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_entry = mem[rd_ptr_reg];

    assign do_push = push_valid && !q_full;
    assign do_pop  = pop_valid && pop_ready;

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage write
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/vdpd_back.sv */
// Back end: varint assembly, delta accumulation, checks and result register.
`default_nettype none

module vdpd_back
    import vdpd_pkg::*;
#(
    parameter int MAX_GROUP_BYTES = DEFAULT_MAX_GROUP_BYTES
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [VERSE_W-1:0]  cfg_wdata,
    input  wire logic                pop_valid,
    input  wire q_entry_t            pop_entry,
    output logic                     pop_ready,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [VERSE_W-1:0]       verse_number,
    output logic [STATUS_W-1:0]      status,
    output logic                     last
);

    localparam int SH_W = 6;

    logic [VERSE_W-1:0]  verse_limit_reg;
    logic [GAP_W-1:0]    gap_accum_reg,     gap_accum_next;
    logic [STEP_W-1:0]   shift_step_reg,    shift_step_next;
    logic [VERSE_W-1:0]  running_verse_reg, running_verse_next;
    logic [LEN_W-1:0]    postings_left_reg, postings_left_next;
    logic                first_pending_reg, first_pending_next;
    logic                list_active_reg,   list_active_next;
    logic                out_valid_reg,     out_valid_next;
    logic [VERSE_W-1:0]  verse_reg,         verse_next;
    logic [STATUS_W-1:0] status_reg,        status_next;
    logic                last_reg,          last_next;

    logic                do_op, emit;
    logic [SH_W-1:0]     sh_amt;
    logic [GAP_W-1:0]    gap_full;
    logic [STEP_W-1:0]   step_inc;
    logic [GAP_W:0]      verse_sum;
    logic [LEN_W-1:0]    left_dec;

    // Take an operation when the result register is free or draining
    assign pop_ready = !out_valid_reg || !out_stall;
    assign do_op     = pop_valid && pop_ready;

    // Datapath pieces
    assign sh_amt    = SH_W'(shift_step_reg) * SH_W'(GROUP_W);
    assign gap_full  = gap_accum_reg | (GAP_W'(pop_entry.data_byte[GROUP_W-1:0]) << sh_amt);
    assign step_inc  = shift_step_reg + 1'b1;
    assign verse_sum = {{(GAP_W + 1 - VERSE_W){1'b0}}, running_verse_reg}
                     + {1'b0, gap_full};
    assign left_dec  = postings_left_reg - 1'b1;

    // Decode step
    always_comb
    begin
        gap_accum_next     = gap_accum_reg;
        shift_step_next    = shift_step_reg;
        running_verse_next = running_verse_reg;
        postings_left_next = postings_left_reg;
        first_pending_next = first_pending_reg;
        list_active_next   = list_active_reg;
        emit               = 1'b0;
        verse_next         = verse_reg;
        status_next        = status_reg;
        last_next          = last_reg;

        if (do_op)
        begin
            case (pop_entry.op)
                OP_START:
                begin
                    gap_accum_next     = '0;
                    shift_step_next    = '0;
                    running_verse_next = '0;
                    first_pending_next = 1'b1;
                    postings_left_next = pop_entry.list_length;
                    if (pop_entry.list_length == '0)
                    begin
                        list_active_next = 1'b0;
                        emit        = 1'b1;
                        verse_next  = '0;
                        status_next = ST_EMPTY;
                        last_next   = 1'b1;
                    end
                    else
                    begin
                        list_active_next = 1'b1;
                    end
                end
                OP_END:
                begin
                    if (list_active_reg)
                    begin
                        list_active_next = 1'b0;
                        gap_accum_next   = '0;
                        shift_step_next  = '0;
                        emit        = 1'b1;
                        verse_next  = '0;
                        status_next = ST_ENDED;
                        last_next   = 1'b1;
                    end
                end
                OP_DATA:
                begin
                    if (list_active_reg)
                    begin
                        gap_accum_next  = '0;
                        shift_step_next = '0;
                        verse_next      = '0;
                        last_next       = 1'b1;
                        if (pop_entry.data_byte[BYTE_W-1])
                        begin
                            // Continuation byte
                            if (step_inc >= STEP_W'(MAX_GROUP_BYTES))
                            begin
                                list_active_next = 1'b0;
                                emit        = 1'b1;
                                status_next = ST_TOO_LONG;
                            end
                            else
                            begin
                                gap_accum_next  = gap_full;
                                shift_step_next = step_inc;
                            end
                        end
                        else if (!first_pending_reg && gap_full == '0)
                        begin
                            list_active_next = 1'b0;
                            emit        = 1'b1;
                            status_next = ST_NOT_ASC;
                        end
                        else if (verse_sum >= {{(GAP_W + 1 - VERSE_W){1'b0}}, verse_limit_reg})
                        begin
                            list_active_next = 1'b0;
                            emit        = 1'b1;
                            status_next = ST_RANGE;
                        end
                        else
                        begin
                            // Good posting
                            running_verse_next = verse_sum[VERSE_W-1:0];
                            first_pending_next = 1'b0;
                            postings_left_next = left_dec;
                            list_active_next   = (left_dec != '0);
                            emit        = 1'b1;
                            verse_next  = verse_sum[VERSE_W-1:0];
                            status_next = ST_POSTING;
                            last_next   = (left_dec == '0);
                        end
                    end
                end
                default:
                begin
                    emit = 1'b0;
                end
            endcase
        end
    end

    // Result register valid
    always_comb
    begin
        if (do_op && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            verse_limit_reg   <= '0;
            gap_accum_reg     <= '0;
            shift_step_reg    <= '0;
            running_verse_reg <= '0;
            postings_left_reg <= '0;
            first_pending_reg <= 1'b1;
            list_active_reg   <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                verse_limit_reg <= cfg_wdata;
            end
            gap_accum_reg     <= gap_accum_next;
            shift_step_reg    <= shift_step_next;
            running_verse_reg <= running_verse_next;
            postings_left_reg <= postings_left_next;
            first_pending_reg <= first_pending_next;
            list_active_reg   <= list_active_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (do_op && emit)
        begin
            verse_reg  <= verse_next;
            status_reg <= status_next;
            last_reg   <= last_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign verse_number = verse_reg;
    assign status       = status_reg;
    assign last         = last_reg;

endmodule

`default_nettype wire

/* rtl/core/varint_delta_postings_decoder_core.sv */
// Top level of the varint delta postings decoder.
//
//  Channel  Handshake            Payload                       Notes
//  in       in_valid/in_stall    cmd, data_byte, list_length   one command per transfer
//  out      out_valid/out_stall  verse_number, status, last    zero or one result per command
//  cfg      cfg_we               cfg_wdata                     verse_limit, write only
//
// One input transfer per cycle sustained while the queue has room; the decode step (OR of
// the 7-bit group, one 33-bit add and compare) runs once per cycle in the back end while
// the result register is free or draining. A result is valid once its input has passed
// the queue and then the result register.
// Reset is asynchronous and clears the queue, list state and verse_limit.
// The input stalls only when the QUEUE_DEPTH-entry queue is full; the back
// end keeps going while a waiting result is taken in the same cycle.
`default_nettype none

module varint_delta_postings_decoder_core
    import vdpd_pkg::*;
#(
    parameter int MAX_GROUP_BYTES = DEFAULT_MAX_GROUP_BYTES,
    parameter int QUEUE_DEPTH     = DEFAULT_QUEUE_DEPTH
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [CMD_W-1:0]    cmd,
    input  wire logic [BYTE_W-1:0]   data_byte,
    input  wire logic [LEN_W-1:0]    list_length,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [VERSE_W-1:0]       verse_number,
    output logic [STATUS_W-1:0]      status,
    output logic                     last,
    input  wire logic                cfg_we,
    input  wire logic [VERSE_W-1:0]  cfg_wdata
);

    logic     push_valid;
    q_entry_t push_entry;
    logic     q_full;
    logic     pop_valid;
    q_entry_t pop_entry;
    logic     pop_ready;

    vdpd_front u_front
    (
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .data_byte   (data_byte),
        .list_length (list_length),
        .push_valid  (push_valid),
        .push_entry  (push_entry),
        .q_full      (q_full)
    );

    vdpd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .q_full     (q_full),
        .pop_valid  (pop_valid),
        .pop_entry  (pop_entry),
        .pop_ready  (pop_ready)
    );

    vdpd_back #(
        .MAX_GROUP_BYTES (MAX_GROUP_BYTES)
    ) u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .pop_valid    (pop_valid),
        .pop_entry    (pop_entry),
        .pop_ready    (pop_ready),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .verse_number (verse_number),
        .status       (status),
        .last         (last)
    );

endmodule

`default_nettype wire
